>>> rtl/cflp_pkg.sv
`default_nettype none
package cflp_pkg;

  localparam int MAX_NEIGHBOURS = 64;
  localparam int FRACTION_BITS  = 16;

  localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int TOT_W  = $clog2(MAX_NEIGHBOURS * 255 + 1);
  localparam int SQ_W   = $clog2(MAX_NEIGHBOURS * 65025 + 1);

  localparam int ALPHA_W = 25;
  localparam int BETA_W  = 34;
  localparam int ALPHA_LIMIT = 255 * (1 << FRACTION_BITS);

  // Shared multiplier operands and product.
  localparam int MA_W = 26;
  localparam int MB_W = 23;
  localparam int P_W  = MA_W + MB_W;

  localparam int DEN_W = 31;
  localparam int DVD_W = 48;
  localparam int DSR_W = 31;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam logic [1:0] FIT_OK    = 2'd0;
  localparam logic [1:0] FIT_CONST = 2'd1;
  localparam logic [1:0] FIT_FEW   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACC,
    OP_CHECK,
    OP_MUL_NSQ,
    OP_MUL_LL,
    OP_MUL_NX,
    OP_MUL_LC,
    OP_NUM,
    OP_ALPHA_LOAD,
    OP_DIV,
    OP_ALPHA_SET,
    OP_MUL_AL,
    OP_BETA_LOAD,
    OP_BETA_SET,
    OP_FIT_OUT,
    OP_PRED_MUL,
    OP_PRED_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic few_pairs;
    logic denom_zero;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/cflp_ctrl.sv
`default_nettype none
module cflp_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_mode,
  input  wire                  in_last,
  output logic                 in_ready,
  output cflp_pkg::dp_cmd_t    cmd,
  input  cflp_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    IDLE, CHK, D1, D2, D3, D4, D5, DEC, ADIV, AFIN, B1, BLOAD, BDIV, BFIN, FOUT, PMUL
  } state_t;

  state_t state, state_next;
  logic   pred_out;
  logic   pred_out_next;

  always_comb begin
    state_next    = state;
    pred_out_next = pred_out;
    cmd.op        = cflp_pkg::OP_NONE;
    in_ready      = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_mode) begin
            cmd.op = cflp_pkg::OP_ACC;
            if (in_last) state_next = CHK;
          end else begin
            state_next = PMUL;
          end
        end
      end
      CHK: begin
        cmd.op = cflp_pkg::OP_CHECK;
        state_next = status.few_pairs ? FOUT : D1;
      end
      D1: begin cmd.op = cflp_pkg::OP_MUL_NSQ; state_next = D2; end
      D2: begin cmd.op = cflp_pkg::OP_MUL_LL;  state_next = D3; end
      D3: begin cmd.op = cflp_pkg::OP_MUL_NX;  state_next = D4; end
      D4: begin cmd.op = cflp_pkg::OP_MUL_LC;  state_next = D5; end
      D5: begin cmd.op = cflp_pkg::OP_NUM;     state_next = DEC; end
      DEC: begin
        cmd.op = cflp_pkg::OP_ALPHA_LOAD;
        state_next = status.denom_zero ? B1 : ADIV;
      end
      ADIV: begin
        cmd.op = cflp_pkg::OP_DIV;
        if (status.div_last) state_next = AFIN;
      end
      AFIN:  begin cmd.op = cflp_pkg::OP_ALPHA_SET; state_next = B1; end
      B1:    begin cmd.op = cflp_pkg::OP_MUL_AL;    state_next = BLOAD; end
      BLOAD: begin cmd.op = cflp_pkg::OP_BETA_LOAD; state_next = BDIV; end
      BDIV: begin
        cmd.op = cflp_pkg::OP_DIV;
        if (status.div_last) state_next = BFIN;
      end
      BFIN: begin cmd.op = cflp_pkg::OP_BETA_SET; state_next = FOUT; end
      FOUT: begin
        cmd.op = pred_out ? cflp_pkg::OP_PRED_OUT : cflp_pkg::OP_FIT_OUT;
        if (status.out_free) state_next = IDLE;
      end
      PMUL: begin
        cmd.op = cflp_pkg::OP_PRED_MUL;
        state_next = FOUT;
      end
      default: state_next = IDLE;
    endcase
    if (state == IDLE) pred_out_next = in_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      pred_out <= 1'b0;
    end else begin
      state    <= state_next;
      pred_out <= pred_out_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cflp_datapath.sv
`default_nettype none
module cflp_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_fire,
  input  wire  [7:0]                  in_luma,
  input  wire  [7:0]                  in_chroma,
  input  wire                         in_last,
  input  cflp_pkg::dp_cmd_t           cmd,
  output cflp_pkg::dp_status_t        status,
  input  wire                         out_ready,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [7:0]                  out_pred,
  output logic [cflp_pkg::ALPHA_W-1:0] out_slope,
  output logic [32:0]                 out_offset,
  output logic [1:0]                  out_status,
  output logic                        out_last
);

  localparam int FB = cflp_pkg::FRACTION_BITS;

  logic [cflp_pkg::CNT_W-1:0]     pair_count;
  logic [cflp_pkg::TOT_W-1:0]     luma_total;
  logic [cflp_pkg::TOT_W-1:0]     chroma_total;
  logic [cflp_pkg::SQ_W-1:0]      luma_square_total;
  logic [cflp_pkg::SQ_W-1:0]      cross_total;
  logic signed [cflp_pkg::ALPHA_W-1:0] alpha;
  logic signed [cflp_pkg::BETA_W-1:0]  beta;
  logic [7:0]                     luma_r;
  logic                           last_r;
  logic [1:0]                     fit_status;

  logic signed [cflp_pkg::P_W-1:0]   prod;
  logic signed [cflp_pkg::DEN_W-1:0] denom;
  logic signed [cflp_pkg::DEN_W-1:0] num;

  logic [cflp_pkg::DVD_W-1:0]  dvd;
  logic [cflp_pkg::DSR_W-1:0]  dsr;
  logic [cflp_pkg::DSR_W-1:0]  rem;
  logic [cflp_pkg::DCNT_W-1:0] div_cnt;
  logic                        neg;

  logic signed [cflp_pkg::MA_W-1:0] mul_a;
  logic signed [cflp_pkg::MB_W-1:0] mul_b;
  logic [cflp_pkg::DSR_W:0]         rem_sh;
  logic                             ge;
  logic signed [cflp_pkg::P_W-1:0]  alpha_num;
  logic signed [cflp_pkg::P_W-1:0]  beta_num;
  logic signed [cflp_pkg::P_W-1:0]  q_signed;
  logic signed [cflp_pkg::P_W:0]    v;
  logic signed [cflp_pkg::P_W:0]    p_full;
  logic [7:0]                       pred;
  logic                             free;
  logic [15:0]                      lc;
  logic [15:0]                      lsq;

  assign free = !out_valid || out_ready;
  assign lc   = in_luma * in_chroma;
  assign lsq  = 16'(in_luma) * 16'(in_luma);

  assign status.few_pairs  = pair_count < cflp_pkg::CNT_W'(4);
  assign status.denom_zero = denom == '0;
  assign status.div_last   = div_cnt == cflp_pkg::DCNT_W'(1);
  assign status.out_free   = free;

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      cflp_pkg::OP_MUL_NSQ: begin
        mul_a = cflp_pkg::MA_W'(pair_count);
        mul_b = cflp_pkg::MB_W'(luma_square_total);
      end
      cflp_pkg::OP_MUL_LL: begin
        mul_a = cflp_pkg::MA_W'(luma_total);
        mul_b = cflp_pkg::MB_W'(luma_total);
      end
      cflp_pkg::OP_MUL_NX: begin
        mul_a = cflp_pkg::MA_W'(pair_count);
        mul_b = cflp_pkg::MB_W'(cross_total);
      end
      cflp_pkg::OP_MUL_LC: begin
        mul_a = cflp_pkg::MA_W'(luma_total);
        mul_b = cflp_pkg::MB_W'(chroma_total);
      end
      cflp_pkg::OP_MUL_AL: begin
        mul_a = cflp_pkg::MA_W'(alpha);
        mul_b = cflp_pkg::MB_W'(luma_total);
      end
      cflp_pkg::OP_PRED_MUL: begin
        mul_a = cflp_pkg::MA_W'(alpha);
        mul_b = cflp_pkg::MB_W'(luma_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rem_sh    = {rem, dvd[cflp_pkg::DVD_W-1]};
    ge        = rem_sh >= {1'b0, dsr};
    alpha_num = (cflp_pkg::P_W'(num) <<< (FB + 1)) + cflp_pkg::P_W'(denom);
    beta_num  = ((cflp_pkg::P_W'(chroma_total) << FB) - prod) <<< 1;
    beta_num  = beta_num + cflp_pkg::P_W'(pair_count);
    if (neg) q_signed = -(cflp_pkg::P_W'(dvd) + cflp_pkg::P_W'(rem != '0));
    else     q_signed = cflp_pkg::P_W'(dvd);
    v      = (cflp_pkg::P_W+1)'(prod) + (cflp_pkg::P_W+1)'(beta)
             + (cflp_pkg::P_W+1)'(1 << (FB - 1));
    p_full = v >>> FB;
    if (v < 0)                              pred = 8'd0;
    else if (p_full > (cflp_pkg::P_W+1)'(255)) pred = 8'd255;
    else                                     pred = p_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count        <= '0;
      luma_total        <= '0;
      chroma_total      <= '0;
      luma_square_total <= '0;
      cross_total       <= '0;
      alpha             <= '0;
      beta              <= cflp_pkg::BETA_W'(128) << FB;
      out_valid         <= 1'b0;
      div_cnt           <= '0;
    end else begin
      if (free && (cmd.op == cflp_pkg::OP_FIT_OUT || cmd.op == cflp_pkg::OP_PRED_OUT))
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
      if (in_fire) begin
        luma_r <= in_luma;
        last_r <= in_last;
      end
      case (cmd.op)
        cflp_pkg::OP_ACC: begin
          if (pair_count < cflp_pkg::CNT_W'(cflp_pkg::MAX_NEIGHBOURS)) begin
            pair_count        <= pair_count + 1'b1;
            luma_total        <= luma_total + cflp_pkg::TOT_W'(in_luma);
            chroma_total      <= chroma_total + cflp_pkg::TOT_W'(in_chroma);
            luma_square_total <= luma_square_total + cflp_pkg::SQ_W'(lsq);
            cross_total       <= cross_total + cflp_pkg::SQ_W'(lc);
          end
        end
        cflp_pkg::OP_CHECK: fit_status <= cflp_pkg::FIT_FEW;
        cflp_pkg::OP_MUL_NSQ, cflp_pkg::OP_MUL_AL, cflp_pkg::OP_PRED_MUL:
          prod <= mul_a * mul_b;
        cflp_pkg::OP_MUL_LL: begin
          prod  <= mul_a * mul_b;
          denom <= cflp_pkg::DEN_W'(prod);
        end
        cflp_pkg::OP_MUL_NX: begin
          prod  <= mul_a * mul_b;
          denom <= denom - cflp_pkg::DEN_W'(prod);
        end
        cflp_pkg::OP_MUL_LC: begin
          prod <= mul_a * mul_b;
          num  <= cflp_pkg::DEN_W'(prod);
        end
        cflp_pkg::OP_NUM: num <= num - cflp_pkg::DEN_W'(prod);
        cflp_pkg::OP_ALPHA_LOAD: begin
          if (denom == '0) begin
            alpha      <= '0;
            fit_status <= cflp_pkg::FIT_CONST;
          end else begin
            fit_status <= cflp_pkg::FIT_OK;
            neg        <= alpha_num < 0;
            dvd        <= cflp_pkg::DVD_W'(alpha_num < 0 ? -alpha_num : alpha_num);
            dsr        <= cflp_pkg::DSR_W'(denom) << 1;
            rem        <= '0;
            div_cnt    <= cflp_pkg::DCNT_W'(cflp_pkg::DVD_W);
          end
        end
        cflp_pkg::OP_BETA_LOAD: begin
          neg     <= beta_num < 0;
          dvd     <= cflp_pkg::DVD_W'(beta_num < 0 ? -beta_num : beta_num);
          dsr     <= cflp_pkg::DSR_W'(pair_count) << 1;
          rem     <= '0;
          div_cnt <= cflp_pkg::DCNT_W'(cflp_pkg::DVD_W);
        end
        cflp_pkg::OP_DIV: begin
          rem     <= ge ? cflp_pkg::DSR_W'(rem_sh - {1'b0, dsr}) : cflp_pkg::DSR_W'(rem_sh);
          dvd     <= {dvd[cflp_pkg::DVD_W-2:0], ge};
          div_cnt <= div_cnt - 1'b1;
        end
        cflp_pkg::OP_ALPHA_SET: begin
          if (q_signed > cflp_pkg::P_W'(cflp_pkg::ALPHA_LIMIT))
            alpha <= cflp_pkg::ALPHA_W'(cflp_pkg::ALPHA_LIMIT);
          else if (q_signed < -cflp_pkg::P_W'(cflp_pkg::ALPHA_LIMIT))
            alpha <= -cflp_pkg::ALPHA_W'(cflp_pkg::ALPHA_LIMIT);
          else
            alpha <= cflp_pkg::ALPHA_W'(q_signed);
        end
        cflp_pkg::OP_BETA_SET: beta <= cflp_pkg::BETA_W'(q_signed);
        cflp_pkg::OP_FIT_OUT: begin
          if (free) begin
            out_kind          <= 1'b0;
            out_pred          <= 8'd0;
            out_slope         <= alpha;
            out_offset        <= beta[32:0];
            out_status        <= fit_status;
            out_last          <= last_r;
            pair_count        <= '0;
            luma_total        <= '0;
            chroma_total      <= '0;
            luma_square_total <= '0;
            cross_total       <= '0;
          end
        end
        cflp_pkg::OP_PRED_OUT: begin
          if (free) begin
            out_kind   <= 1'b1;
            out_pred   <= pred;
            out_slope  <= alpha;
            out_offset <= beta[32:0];
            out_status <= cflp_pkg::FIT_OK;
            out_last   <= last_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    pair_count <= cflp_pkg::CNT_W'(cflp_pkg::MAX_NEIGHBOURS))
    else $error("pair count above capacity");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    (alpha <= cflp_pkg::ALPHA_W'(cflp_pkg::ALPHA_LIMIT))
    && (alpha >= -cflp_pkg::ALPHA_W'(cflp_pkg::ALPHA_LIMIT)))
    else $error("slope outside saturation range");

  a_clear_after_fit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == cflp_pkg::OP_FIT_OUT && free) |=> (pair_count == '0))
    else $error("sums not cleared after fit report");

endmodule
`default_nettype wire

>>> rtl/chroma_from_luma_fit_predict.sv
// A neighbour pair without last is absorbed at its transfer with no result. A last pair yields
// its fit report after two 48-step divisions (slope, then offset) on one shared divider; for
// constant luma only the offset division runs, and for too few pairs neither runs.
// A luma sample yields its prediction through the PMUL and FOUT states, before another is taken.
// Pairs are taken one per cycle while idle; input waits while a fit runs and on a held result.
// Reset (rst, synchronous, active high) clears the sums and count, slope to 0, offset 128.
`default_nettype none
module chroma_from_luma_fit_predict (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // luma_sample [7:0], chroma_sample [15:8]
  input  wire         s_tuser,   // mode
  input  wire         s_tlast,   // last
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // chroma_pred [7:0], alpha_q [32:8], beta_q [65:33],
                                 // fit_status [67:66], zero fill [71:68]
  output logic        m_tuser,   // kind
  output logic        m_tlast    // end_mark
);

  cflp_pkg::dp_cmd_t    cmd;
  cflp_pkg::dp_status_t status;

  logic [7:0]                   out_pred;
  logic [cflp_pkg::ALPHA_W-1:0] out_slope;
  logic [32:0]                  out_offset;
  logic [1:0]                   out_status;

  // The controller sequences the fit and prediction steps.
  cflp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the sums, the model, the shared multiplier and divider,
  // and the output register that parts the two sides.
  cflp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (s_tvalid && s_tready),
    .in_luma    (s_tdata[7:0]),
    .in_chroma  (s_tdata[15:8]),
    .in_last    (s_tlast),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_kind   (m_tuser),
    .out_pred   (out_pred),
    .out_slope  (out_slope),
    .out_offset (out_offset),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0000, out_status, out_offset, out_slope, out_pred};

endmodule
`default_nettype wire
